>>> design/uer_pkg.sv
// Shared types, constants and reset values for the ultrasonic echo ranger.
package uer_pkg;

    // Field widths
    localparam int TIMEOUT_W  = 16;
    localparam int TRIGLEN_W  = 8;
    localparam int PAUSE_W    = 20;
    localparam int DIST_W     = 21;
    localparam int ELAPSED_W  = 17;
    localparam int WIDTH_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGLEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THR = 2'd3;

    // Configuration reset values
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd13200;
    localparam logic [TRIGLEN_W-1:0] TRIGLEN_RST  = 8'd10;
    localparam logic [PAUSE_W-1:0]   PAUSE_RST    = 20'd1000000;
    localparam logic [DIST_W-1:0]    NEAR_THR_RST = 21'd2000;

    // Counter saturation limits
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [WIDTH_W-1:0]   WIDTH_MAX   = '1;

    // Ranging sequence phases
    typedef enum logic [1:0] {
        PH_TRIG  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_HIGH  = 2'd2,
        PH_PAUSE = 2'd3
    } phase_t;

    // Live configuration
    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_us;
        logic [TRIGLEN_W-1:0] trigger_len_us;
        logic [PAUSE_W-1:0]   pause_us;
        logic [DIST_W-1:0]    near_threshold;
    } uer_cfg_t;

    // One tick's result
    typedef struct packed {
        logic               trigger_out;
        logic               led_out;
        logic               done_res;
        logic               timed_out;
        logic [WIDTH_W-1:0] echo_width_us;
        logic [DIST_W-1:0]  distance_mcm;
    } uer_result_t;

    // Distance in thousandths of a cm: width * 17 = (width << 4) + width
    function automatic logic [DIST_W-1:0] width_to_mcm(input logic [WIDTH_W-1:0] w);
        logic [DIST_W-1:0] wx;
        wx = {{(DIST_W-WIDTH_W){1'b0}}, w};
        return (wx << 4) + wx;
    endfunction

endpackage

>>> design/uer_core.sv
// Ranging sequencer: phase and counter state, advanced once per accepted tick.
module uer_core
    import uer_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  logic        echo_level,
    input  uer_cfg_t    cfg,
    output uer_result_t res
);

    phase_t               phase_reg, phase_next;
    logic [PAUSE_W-1:0]   phase_count_reg, phase_count_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [WIDTH_W-1:0]   width_count_reg, width_count_next;
    logic                 led_reg, led_next;

    logic [PAUSE_W-1:0]   pc_inc;
    logic [ELAPSED_W-1:0] el_inc;
    logic [WIDTH_W-1:0]   wd_inc;
    logic                 el_over;
    logic                 done;
    logic                 tmo;
    logic [WIDTH_W-1:0]   width;
    logic [DIST_W-1:0]    dist_mcm;

    assign pc_inc   = phase_count_reg + 1'b1;
    assign el_inc   = (elapsed_reg == ELAPSED_MAX) ? ELAPSED_MAX : elapsed_reg + 1'b1;
    assign wd_inc   = (width_count_reg == WIDTH_MAX) ? WIDTH_MAX : width_count_reg + 1'b1;
    assign el_over  = el_inc > {1'b0, cfg.timeout_us};
    assign dist_mcm = width_to_mcm(width);

    // Next state and result for the current tick
    always_comb
    begin
        phase_next       = phase_reg;
        phase_count_next = phase_count_reg;
        elapsed_next     = elapsed_reg;
        width_count_next = width_count_reg;
        led_next         = led_reg;
        done             = 1'b0;
        tmo              = 1'b0;
        width            = '0;
        res.trigger_out  = 1'b0;

        case (phase_reg)
            PH_TRIG:
            begin
                res.trigger_out  = 1'b1;
                phase_count_next = pc_inc;
                if (pc_inc >= {{(PAUSE_W-TRIGLEN_W){1'b0}}, cfg.trigger_len_us})
                begin
                    phase_next       = PH_WAIT;
                    phase_count_next = '0;
                    elapsed_next     = '0;
                    width_count_next = '0;
                end
            end
            PH_WAIT:
            begin
                elapsed_next = el_inc;
                if (echo_level)
                begin
                    phase_next       = PH_HIGH;
                    width_count_next = {{(WIDTH_W-1){1'b0}}, 1'b1};
                end
                else if (el_over)
                begin
                    done = 1'b1;
                    tmo  = 1'b1;
                end
            end
            PH_HIGH:
            begin
                elapsed_next = el_inc;
                if (!echo_level)
                begin
                    done  = 1'b1;
                    width = width_count_reg;
                end
                else if (el_over)
                begin
                    done = 1'b1;
                    tmo  = 1'b1;
                end
                else
                begin
                    width_count_next = wd_inc;
                end
            end
            PH_PAUSE:
            begin
                phase_count_next = pc_inc;
                if (pc_inc >= cfg.pause_us)
                begin
                    phase_next       = PH_TRIG;
                    phase_count_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_TRIG;
            end
        endcase

        // Measurement complete: update LED and start the pause, or retrigger if the pause is zero
        if (done)
        begin
            led_next         = dist_mcm < cfg.near_threshold;
            phase_count_next = '0;
            elapsed_next     = '0;
            width_count_next = '0;
            phase_next       = (cfg.pause_us == '0) ? PH_TRIG : PH_PAUSE;
        end

        res.led_out       = led_next;
        res.done_res      = done;
        res.timed_out     = tmo;
        res.echo_width_us = width;
        res.distance_mcm  = dist_mcm;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_TRIG;
            phase_count_reg <= '0;
            elapsed_reg     <= '0;
            width_count_reg <= '0;
            led_reg         <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            phase_count_reg <= phase_count_next;
            elapsed_reg     <= elapsed_next;
            width_count_reg <= width_count_next;
            led_reg         <= led_next;
        end
    end

endmodule

>>> design/ultrasonic_echo_ranger_unit.sv
// Ultrasonic echo ranger top level: configuration registers, sequencer and result register.
//
// Each input transaction is one microsecond tick carrying the sampled echo level, and
// produces exactly one result transaction in the next cycle. A transaction is accepted every
// cycle; the only limit is the single result register, so input stall follows output stall
// only while that register holds a result that has not been taken. The block cycles through
// trigger, wait-for-echo, echo-high and pause; done_res marks the tick a measurement ends,
// with echo_width_us and distance_mcm (width * 17, thousandths of a cm) valid on that tick
// and zero otherwise. Configuration registers take effect on the next accepted tick.
module ultrasonic_echo_ranger_unit
    import uer_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  echo_level,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  trigger_out,
    output logic                  led_out,
    output logic                  done_res,
    output logic                  timed_out,
    output logic [WIDTH_W-1:0]    echo_width_us,
    output logic [DIST_W-1:0]     distance_mcm
);

    uer_cfg_t    cfg_reg;
    uer_result_t res;
    uer_result_t res_reg;
    logic        out_valid_reg, out_valid_next;
    logic        in_accept;

    // Handshake
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_us     <= TIMEOUT_RST;
            cfg_reg.trigger_len_us <= TRIGLEN_RST;
            cfg_reg.pause_us       <= PAUSE_RST;
            cfg_reg.near_threshold <= NEAR_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT:  cfg_reg.timeout_us     <= cfg_data[TIMEOUT_W-1:0];
                CFG_TRIGLEN:  cfg_reg.trigger_len_us <= cfg_data[TRIGLEN_W-1:0];
                CFG_PAUSE:    cfg_reg.pause_us       <= cfg_data[PAUSE_W-1:0];
                CFG_NEAR_THR: cfg_reg.near_threshold <= cfg_data[DIST_W-1:0];
                default:      ;
            endcase
        end
    end

    // Sequencer
    uer_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (in_accept),
        .echo_level (echo_level),
        .cfg        (cfg_reg),
        .res        (res)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            res_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign trigger_out   = res_reg.trigger_out;
    assign led_out       = res_reg.led_out;
    assign done_res      = res_reg.done_res;
    assign timed_out     = res_reg.timed_out;
    assign echo_width_us = res_reg.echo_width_us;
    assign distance_mcm  = res_reg.distance_mcm;

endmodule

>>> design/uer_checker.sv
// Port-level assertions for the ultrasonic echo ranger, bound to the top level.
module uer_checker
    import uer_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic               trigger_out,
    input logic               led_out,
    input logic               done_res,
    input logic               timed_out,
    input logic [WIDTH_W-1:0] echo_width_us,
    input logic [DIST_W-1:0]  distance_mcm
);

    // A timeout is always reported as a completed measurement of width zero
    a_timeout_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> done_res && echo_width_us == '0)
        else $error("timeout without done or with nonzero width");

    // Ticks that complete nothing carry no measurement
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> echo_width_us == '0 && distance_mcm == '0 && !timed_out)
        else $error("measurement fields set on a non-completing tick");

    // Distance tracks width times 17
    a_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance_mcm == width_to_mcm(echo_width_us))
        else $error("distance does not match echo width");

    // A measurement never completes on a trigger tick
    a_no_trig_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !trigger_out)
        else $error("done reported during trigger");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(led_out) && $stable(echo_width_us))
        else $error("stalled result changed");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .trigger_out   (trigger_out),
    .led_out       (led_out),
    .done_res      (done_res),
    .timed_out     (timed_out),
    .echo_width_us (echo_width_us),
    .distance_mcm  (distance_mcm)
);
